>>> src/sntp_pkg.sv
// Shared types, constants and register codes for the SNTP poll scheduler.
// No dependencies; compiled before every other file of the block.
package sntp_pkg;

    localparam logic [14:0] RETRY_CAP_MS   = 15'd30000;
    localparam logic [14:0] RETRY_INIT_MS  = 15'd1;
    localparam logic [31:0] NTP_TO_UNIX    = 32'd2208988800;
    localparam int          MS_PER_SEC     = 1000;
    localparam int          SECS_PER_DAY   = 86400;
    localparam int          SECS_PER_HOUR  = 3600;
    localparam int          SECS_PER_MIN   = 60;
    localparam int          DAYS_PER_WEEK  = 7;
    localparam logic [15:0] EPOCH_WEEKDAY  = 16'd4;

    localparam logic signed [17:0] TIME_OFFSET_RST = 18'sd0;
    localparam logic [31:0]        INTERVAL_RST    = 32'd60000;
    localparam logic [15:0]        TIMEOUT_RST     = 16'd1000;

    localparam logic [1:0] CFG_TIME_OFFSET     = 2'd0;
    localparam logic [1:0] CFG_UPDATE_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_REQUEST_TIMEOUT = 2'd2;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic        reply_valid;
        logic [31:0] reply_seconds;
    } poll_t;

    typedef struct packed {
        logic        send_request;
        logic        purge_receive;
        logic        synced;
        logic [31:0] epoch_seconds;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
        logic [2:0]  weekday;
    } result_t;

    typedef struct packed {
        logic signed [17:0] time_offset;
        logic [31:0]        update_interval_ms;
        logic [15:0]        request_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic send_request;
        logic purge_receive;
        logic synced;
    } flags_t;

    typedef struct packed {
        flags_t      flags;
        logic [31:0] delta_ms;
        logic [31:0] base;
    } sched_t;

endpackage

>>> src/sntp_if.sv
// Handshake channels of the SNTP poll scheduler: poll, result and config write.
// Depends on sntp_pkg for the payload types.
interface sntp_poll_if;
    logic                valid;
    logic                ready;
    sntp_pkg::poll_t     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sntp_result_if;
    logic                valid;
    logic                ready;
    sntp_pkg::result_t   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sntp_cfg_if;
    logic                valid;
    logic                ready;
    logic [1:0]          index;
    logic [31:0]         wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> src/sntp_cfg_regs.sv
// Configuration registers: time offset, update interval and request timeout.
// Depends on sntp_pkg and sntp_cfg_if.
module sntp_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    sntp_cfg_if.sink      cfg,
    output sntp_pkg::cfg_t regs
);
    import sntp_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.time_offset        <= TIME_OFFSET_RST;
            regs_reg.update_interval_ms <= INTERVAL_RST;
            regs_reg.request_timeout_ms <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TIME_OFFSET:     regs_reg.time_offset        <= cfg.wdata[17:0];
                CFG_UPDATE_INTERVAL: regs_reg.update_interval_ms <= cfg.wdata;
                CFG_REQUEST_TIMEOUT: regs_reg.request_timeout_ms <= cfg.wdata[15:0];
                default:             ;
            endcase
        end
    end

endmodule

>>> src/sntp_sched.sv
// Poll register, schedule state and backoff decision; emits elapsed time and epoch base.
// Depends on sntp_pkg and sntp_poll_if.
module sntp_sched (
    input  logic             clk,
    input  logic             rst_n,
    input  sntp_pkg::cfg_t   cfg,
    sntp_poll_if.sink        poll,
    output logic             out_valid,
    input  logic             out_ready,
    output sntp_pkg::sched_t out_data
);
    import sntp_pkg::*;

    logic        a_valid_reg;
    poll_t       a_reg;
    logic        b_valid_reg;
    sched_t      b_reg;
    sched_t      b_next;
    logic        b_en;
    logic        step;

    logic [31:0] last_sync_reg, last_sync_next;
    logic [31:0] request_time_reg, request_time_next;
    logic [14:0] retry_reg, retry_next;
    logic [31:0] server_epoch_reg, server_epoch_next;

    logic        due;
    logic [15:0] retry_dbl;
    logic [31:0] deadline;
    logic [31:0] offset_ext;
    flags_t      flags;

    assign b_en       = !b_valid_reg || out_ready;
    assign poll.ready = !a_valid_reg || b_en;
    assign step       = a_valid_reg && b_en;
    assign out_valid  = b_valid_reg;
    assign out_data   = b_reg;

    always_comb
    begin
        last_sync_next    = last_sync_reg;
        request_time_next = request_time_reg;
        retry_next        = retry_reg;
        server_epoch_next = server_epoch_reg;
        flags             = '0;

        due = !(last_sync_reg != 32'd0 &&
                a_reg.now_ms < last_sync_reg + cfg.update_interval_ms);
        retry_dbl = {retry_reg, 1'b0};
        deadline  = request_time_reg + 32'(retry_reg) + 32'(cfg.request_timeout_ms);
        offset_ext = {{14{cfg.time_offset[17]}}, cfg.time_offset};

        if (a_reg.action)
        begin
            last_sync_next    = '0;
            request_time_next = '0;
            retry_next        = RETRY_INIT_MS;
        end
        else if (due)
        begin
            if (request_time_reg == 32'd0 || a_reg.now_ms > deadline)
            begin
                if (request_time_reg != 32'd0)
                    retry_next = (retry_dbl > 16'(RETRY_CAP_MS)) ? RETRY_CAP_MS
                                                                : retry_dbl[14:0];
                else
                    flags.purge_receive = 1'b1;
                flags.send_request = 1'b1;
                request_time_next  = a_reg.now_ms;
            end
            if (a_reg.reply_valid)
            begin
                server_epoch_next = a_reg.reply_seconds - NTP_TO_UNIX;
                request_time_next = '0;
                retry_next        = RETRY_INIT_MS;
                last_sync_next    = a_reg.now_ms;
                flags.synced      = 1'b1;
            end
        end

        b_next.flags    = flags;
        b_next.delta_ms = a_reg.now_ms - last_sync_next;
        b_next.base     = offset_ext + server_epoch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            last_sync_reg    <= '0;
            request_time_reg <= '0;
            retry_reg        <= RETRY_INIT_MS;
            server_epoch_reg <= '0;
        end
        else
        begin
            if (poll.ready)
                a_valid_reg <= poll.valid;
            if (b_en)
                b_valid_reg <= a_valid_reg;
            if (step)
            begin
                last_sync_reg    <= last_sync_next;
                request_time_reg <= request_time_next;
                retry_reg        <= retry_next;
                server_epoch_reg <= server_epoch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
            a_reg <= poll.data;
        if (step)
            b_reg <= b_next;
    end

    a_retry_range: assert property (@(posedge clk) disable iff (!rst_n)
        (retry_reg >= RETRY_INIT_MS) && (retry_reg <= RETRY_CAP_MS))
        else $error("retry delay out of range");

    a_force_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && a_reg.action) |=>
        (last_sync_reg == 32'd0 && request_time_reg == 32'd0 && retry_reg == RETRY_INIT_MS))
        else $error("force update left schedule state");

    a_sync_time: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !a_reg.action && due && a_reg.reply_valid) |=>
        (last_sync_reg == $past(a_reg.now_ms) && request_time_reg == 32'd0))
        else $error("accepted reply did not record sync time");

endmodule

>>> src/sntp_divk.sv
// Two-stage divider by a constant: reciprocal multiply, then quotient and remainder.
// Elastic valid/ready stage carrying a sideband word; no package dependency.
module sntp_divk #(
    parameter int W  = 32,
    parameter int D  = 1000,
    parameter int SW = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [W-1:0]           n,
    input  logic [SW-1:0]          in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [W-1:0]           q,
    output logic [$clog2(D)-1:0]   r,
    output logic [SW-1:0]          out_side
);
    localparam int C  = $clog2(D);
    localparam int S  = W + C;
    localparam int PW = 2 * W + 1;
    localparam logic [W:0] M = (W + 1)'(((64'd1 << S) + 64'(D) - 64'd1) / 64'(D));

    logic          v1_reg;
    logic [PW-1:0] p_reg;
    logic [W-1:0]  n1_reg;
    logic [SW-1:0] side1_reg;
    logic          v2_reg;
    logic [W-1:0]  q_reg;
    logic [C-1:0]  r_reg;
    logic [SW-1:0] side2_reg;

    logic          en1, en2;
    logic [PW-1:0] p_next;
    logic [W-1:0]  q_next;
    logic [W-1:0]  r_full;

    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign q         = q_reg;
    assign r         = r_reg;
    assign out_side  = side2_reg;

    always_comb
    begin
        p_next = PW'(n) * PW'(M);
        q_next = W'(p_reg >> S);
        r_full = n1_reg - q_next * W'(D);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            p_reg     <= p_next;
            n1_reg    <= n;
            side1_reg <= in_side;
        end
        if (en2 && v1_reg)
        begin
            q_reg     <= q_next;
            r_reg     <= r_full[C-1:0];
            side2_reg <= side1_reg;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (int'(r_reg) < D))
        else $error("remainder not below divisor");

endmodule

>>> src/sntp_request_backoff_timekeeper.sv
// Channel   Dir   Payload                                      Beat when
// poll      in    action, now_ms, reply_valid, reply_seconds   poll.valid && poll.ready
// result    out   request flags, local epoch, h/m/s, weekday   result.valid && result.ready
// cfg       in    index, wdata (offset, interval, timeout)     cfg.valid && cfg.ready
//
// One beat per cycle sustained while result.ready stays high. The schedule state
// updates first; the constant divisions then follow in five reciprocal-multiply
// stages. Reset clears all valid flags and the schedule state. Every stage
// advances while the one after it is empty or moving, so polls keep flowing
// while a finished result waits until every stage holds a beat; cfg is always
// ready.
module sntp_request_backoff_timekeeper (
    input  logic          clk,
    input  logic          rst_n,
    sntp_poll_if.sink     poll,
    sntp_result_if.source result,
    sntp_cfg_if.sink      cfg
);
    import sntp_pkg::*;

    typedef struct packed {
        flags_t      flags;
        logic [31:0] base;
    } ms_side_t;

    typedef struct packed {
        flags_t      flags;
        logic [31:0] ep;
    } ep_side_t;

    typedef struct packed {
        flags_t      flags;
        logic [31:0] ep;
        logic [15:0] days;
    } hour_side_t;

    typedef struct packed {
        flags_t      flags;
        logic [31:0] ep;
        logic [15:0] days;
        logic [4:0]  hour;
    } min_side_t;

    typedef struct packed {
        flags_t      flags;
        logic [31:0] ep;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } wday_side_t;

    cfg_t        regs;

    logic        s_valid, s_ready;
    sched_t      s_data;
    ms_side_t    ms_in_side, ms_out_side;

    logic        ms_valid, ms_ready;
    logic [31:0] ms_q;

    logic        ep_valid_reg;
    ep_side_t    ep_reg;
    logic        ep_en;

    logic        day_in_ready, day_valid, day_ready;
    logic [31:0] day_q;
    logic [16:0] day_r;
    ep_side_t    day_out_side;
    hour_side_t  hour_in_side, hour_out_side;

    logic        hour_in_ready, hour_valid, hour_ready;
    logic [16:0] hour_q;
    logic [11:0] hour_r;
    min_side_t   min_in_side, min_out_side;

    logic        min_valid, min_ready;
    logic [11:0] min_q;
    logic [5:0]  min_r;
    wday_side_t  wday_in_side, wday_out_side;
    logic [15:0] wday_n;
    logic [2:0]  wday_r;

    sntp_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    sntp_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (regs),
        .poll      (poll),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .out_data  (s_data)
    );

    assign ms_in_side.flags = s_data.flags;
    assign ms_in_side.base  = s_data.base;

    sntp_divk #(.W(32), .D(MS_PER_SEC), .SW($bits(ms_side_t))) u_div_ms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .n         (s_data.delta_ms),
        .in_side   (ms_in_side),
        .out_valid (ms_valid),
        .out_ready (ms_ready),
        .q         (ms_q),
        .r         (),
        .out_side  (ms_out_side)
    );

    assign ep_en    = !ep_valid_reg || day_in_ready;
    assign ms_ready = ep_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ep_valid_reg <= 1'b0;
        else if (ep_en)
            ep_valid_reg <= ms_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ep_en && ms_valid)
        begin
            ep_reg.flags <= ms_out_side.flags;
            ep_reg.ep    <= ms_out_side.base + ms_q;
        end
    end

    sntp_divk #(.W(32), .D(SECS_PER_DAY), .SW($bits(ep_side_t))) u_div_day (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ep_valid_reg),
        .in_ready  (day_in_ready),
        .n         (ep_reg.ep),
        .in_side   (ep_reg),
        .out_valid (day_valid),
        .out_ready (day_ready),
        .q         (day_q),
        .r         (day_r),
        .out_side  (day_out_side)
    );

    assign hour_in_side.flags = day_out_side.flags;
    assign hour_in_side.ep    = day_out_side.ep;
    assign hour_in_side.days  = day_q[15:0];
    assign day_ready          = hour_in_ready;

    sntp_divk #(.W(17), .D(SECS_PER_HOUR), .SW($bits(hour_side_t))) u_div_hour (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (day_valid),
        .in_ready  (hour_in_ready),
        .n         (day_r),
        .in_side   (hour_in_side),
        .out_valid (hour_valid),
        .out_ready (hour_ready),
        .q         (hour_q),
        .r         (hour_r),
        .out_side  (hour_out_side)
    );

    assign min_in_side.flags = hour_out_side.flags;
    assign min_in_side.ep    = hour_out_side.ep;
    assign min_in_side.days  = hour_out_side.days;
    assign min_in_side.hour  = hour_q[4:0];

    sntp_divk #(.W(12), .D(SECS_PER_MIN), .SW($bits(min_side_t))) u_div_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hour_valid),
        .in_ready  (hour_ready),
        .n         (hour_r),
        .in_side   (min_in_side),
        .out_valid (min_valid),
        .out_ready (min_ready),
        .q         (min_q),
        .r         (min_r),
        .out_side  (min_out_side)
    );

    assign wday_in_side.flags  = min_out_side.flags;
    assign wday_in_side.ep     = min_out_side.ep;
    assign wday_in_side.hour   = min_out_side.hour;
    assign wday_in_side.minute = min_q[5:0];
    assign wday_in_side.second = min_r;
    assign wday_n              = min_out_side.days + EPOCH_WEEKDAY;

    sntp_divk #(.W(16), .D(DAYS_PER_WEEK), .SW($bits(wday_side_t))) u_div_wday (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (min_valid),
        .in_ready  (min_ready),
        .n         (wday_n),
        .in_side   (wday_in_side),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .q         (),
        .r         (wday_r),
        .out_side  (wday_out_side)
    );

    always_comb
    begin
        result.data.send_request     = wday_out_side.flags.send_request;
        result.data.purge_receive    = wday_out_side.flags.purge_receive;
        result.data.synced           = wday_out_side.flags.synced;
        result.data.epoch_seconds    = wday_out_side.ep;
        result.data.hour_of_day      = wday_out_side.hour;
        result.data.minute_of_hour   = wday_out_side.minute;
        result.data.second_of_minute = wday_out_side.second;
        result.data.weekday          = wday_r;
    end

endmodule

>>> tb/sntp_schedule_checker.sv
// Scoreboard for the SNTP poll scheduler: watches the poll, config and result channels.
// Keeps its own schedule state and register copies; uses sntp_pkg for types and codes.
module sntp_schedule_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              poll_valid,
    input  logic              poll_ready,
    input  sntp_pkg::poll_t   poll_data,
    input  logic              res_valid,
    input  logic              res_ready,
    input  sntp_pkg::result_t res_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata,
    output int                errors,
    output int                pending,
    output int                polls_seen,
    output int                results_seen,
    output int                sends_seen,
    output int                purges_seen,
    output int                syncs_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import sntp_pkg::*;

    logic signed [17:0] tz_offset;
    logic [31:0]        interval_ms;
    logic [15:0]        timeout_ms;

    logic [31:0]        last_sync_ms;
    logic [31:0]        req_time_ms;
    logic [14:0]        retry_ms;
    logic [31:0]        srv_epoch;

    result_t            expected_readouts[$];

    task automatic report_mismatch(input string msg);
        if (errors < 30)
            $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    task automatic step_schedule(input poll_t p, output result_t r);
        logic [31:0] due_at;
        logic [31:0] expire_at;
        logic [31:0] doubled;
        logic [31:0] ep;
        logic [31:0] t;
        r = '0;
        if (p.action) begin
            last_sync_ms = '0;
            req_time_ms  = '0;
            retry_ms     = RETRY_INIT_MS;
        end else begin
            due_at = last_sync_ms + interval_ms;
            if (!(last_sync_ms != 0 && p.now_ms < due_at)) begin
                expire_at = req_time_ms + {17'b0, retry_ms} + {16'b0, timeout_ms};
                if (req_time_ms == 0 || p.now_ms > expire_at) begin
                    if (req_time_ms != 0) begin
                        doubled  = {17'b0, retry_ms} << 1;
                        retry_ms = (doubled > {17'b0, RETRY_CAP_MS}) ? RETRY_CAP_MS
                                                                     : doubled[14:0];
                    end else begin
                        r.purge_receive = 1'b1;
                    end
                    r.send_request = 1'b1;
                    req_time_ms    = p.now_ms;
                end
                if (p.reply_valid) begin
                    srv_epoch    = p.reply_seconds - NTP_TO_UNIX;
                    req_time_ms  = '0;
                    retry_ms     = RETRY_INIT_MS;
                    last_sync_ms = p.now_ms;
                    r.synced     = 1'b1;
                end
            end
        end
        ep = {{14{tz_offset[17]}}, tz_offset} + srv_epoch
           + (p.now_ms - last_sync_ms) / MS_PER_SEC;
        r.epoch_seconds = ep;
        t = (ep % SECS_PER_DAY) / SECS_PER_HOUR;
        r.hour_of_day = t[4:0];
        t = (ep % SECS_PER_HOUR) / SECS_PER_MIN;
        r.minute_of_hour = t[5:0];
        t = ep % SECS_PER_MIN;
        r.second_of_minute = t[5:0];
        t = (ep / SECS_PER_DAY + EPOCH_WEEKDAY) % DAYS_PER_WEEK;
        r.weekday = t[2:0];
    endtask

    always @(posedge clk) begin : watch
        result_t want;
        if (!rst_n) begin
            tz_offset    = TIME_OFFSET_RST;
            interval_ms  = INTERVAL_RST;
            timeout_ms   = TIMEOUT_RST;
            last_sync_ms = '0;
            req_time_ms  = '0;
            retry_ms     = RETRY_INIT_MS;
            srv_epoch    = '0;
            expected_readouts.delete();
            errors       = 0;
            polls_seen   = 0;
            results_seen = 0;
            sends_seen   = 0;
            purges_seen  = 0;
            syncs_seen   = 0;
            pending     <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIME_OFFSET:     tz_offset   = cfg_wdata[17:0];
                    CFG_UPDATE_INTERVAL: interval_ms = cfg_wdata;
                    CFG_REQUEST_TIMEOUT: timeout_ms  = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (poll_valid && poll_ready) begin
                step_schedule(poll_data, want);
                expected_readouts.push_back(want);
                polls_seen++;
            end
            if (res_valid && res_ready) begin
                results_seen++;
                if (res_data.send_request === 1'b1)
                    sends_seen++;
                if (res_data.purge_receive === 1'b1)
                    purges_seen++;
                if (res_data.synced === 1'b1)
                    syncs_seen++;
                if (expected_readouts.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no poll waiting",
                                              results_seen));
                end else begin
                    want = expected_readouts.pop_front();
                    compare_field("send_request", res_data.send_request, want.send_request);
                    compare_field("purge_receive", res_data.purge_receive,
                                  want.purge_receive);
                    compare_field("synced", res_data.synced, want.synced);
                    compare_field("epoch_seconds", res_data.epoch_seconds,
                                  want.epoch_seconds);
                    compare_field("hour_of_day", res_data.hour_of_day, want.hour_of_day);
                    compare_field("minute_of_hour", res_data.minute_of_hour,
                                  want.minute_of_hour);
                    compare_field("second_of_minute", res_data.second_of_minute,
                                  want.second_of_minute);
                    compare_field("weekday", res_data.weekday, want.weekday);
                end
            end
            pending <= expected_readouts.size();
        end
    end

endmodule

>>> tb/tb_sntp_request_backoff_timekeeper.sv
// Top of the SNTP poll scheduler bench: clock, reset, poll and config stimulus, result stalls.
// Depends on sntp_pkg, sntp_if, the scheduler RTL and sntp_schedule_checker.
module tb_sntp_request_backoff_timekeeper;
    timeunit 1ns;
    timeprecision 1ps;
    import sntp_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int ITEMS_PER_STEP = 220;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sntp_poll_if   poll_ch();
    sntp_result_if res_ch();
    sntp_cfg_if    cfg_ch();

    int errors;
    int pending;
    int polls_seen;
    int results_seen;
    int sends_seen;
    int purges_seen;
    int syncs_seen;

    bit          hold_req   = 1'b0;
    int          burst_left = 0;
    logic [31:0] clock_ms   = '0;
    logic [15:0] cur_timeout  = TIMEOUT_RST;
    logic [31:0] cur_interval = INTERVAL_RST;

    sntp_request_backoff_timekeeper uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    sntp_schedule_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_ch.valid),
        .poll_ready   (poll_ch.ready),
        .poll_data    (poll_ch.data),
        .res_valid    (res_ch.valid),
        .res_ready    (res_ch.ready),
        .res_data     (res_ch.data),
        .cfg_valid    (cfg_ch.valid),
        .cfg_ready    (cfg_ch.ready),
        .cfg_index    (cfg_ch.index),
        .cfg_wdata    (cfg_ch.wdata),
        .errors       (errors),
        .pending      (pending),
        .polls_seen   (polls_seen),
        .results_seen (results_seen),
        .sends_seen   (sends_seen),
        .purges_seen  (purges_seen),
        .syncs_seen   (syncs_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic poll_t make_poll(input logic action, input logic [31:0] now,
                                        input logic rv, input logic [31:0] rs);
        poll_t p;
        p.action        = action;
        p.now_ms        = now;
        p.reply_valid   = rv;
        p.reply_seconds = rs;
        return p;
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 20);
            1:       return cur_timeout + $urandom_range(0, 40);
            2:       return $urandom_range(0, 3000);
            3:       return cur_interval - 32'd3 + $urandom_range(0, 6);
            default: return $urandom_range(0, 40000);
        endcase
    endfunction

    task automatic offer_poll(input poll_t p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                poll_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        poll_ch.valid <= 1'b1;
        poll_ch.data  <= p;
        @(posedge clk);
        while (!poll_ch.ready) @(posedge clk);
    endtask

    task automatic settle();
        poll_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic program_regs(input int offset, input logic [31:0] interval,
                                input logic [15:0] timeout);
        logic [31:0] offset_word;
        offset_word = offset;
        write_reg(CFG_TIME_OFFSET, offset_word);
        write_reg(CFG_UPDATE_INTERVAL, interval);
        write_reg(CFG_REQUEST_TIMEOUT, {16'b0, timeout});
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        cur_interval = interval;
        cur_timeout  = timeout;
    endtask

    task automatic run_random(input int count);
        int done;
        int kind;
        int len;
        int k;
        done = 0;
        while (done < count) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                len = $urandom_range(4, 25);
                for (k = 0; k < len; k++) begin
                    clock_ms = clock_ms + pick_step();
                    offer_poll(make_poll($urandom_range(0, 49) == 0, clock_ms,
                                         $urandom_range(0, 6) == 0, $urandom));
                end
            end else if (kind <= 5) begin
                len = $urandom_range(3, 20);
                offer_poll(make_poll(1'b1, clock_ms, 1'b0, $urandom));
                for (k = 0; k < len; k++) begin
                    clock_ms = clock_ms + cur_timeout + 32'd30001 + $urandom_range(0, 100);
                    offer_poll(make_poll(1'b0, clock_ms, 1'b0, $urandom));
                end
                clock_ms = clock_ms + $urandom_range(0, 50);
                offer_poll(make_poll(1'b0, clock_ms, 1'b1, $urandom));
                len += 2;
            end else if (kind == 6) begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                len = $urandom_range(5, 15);
                for (k = 0; k < len; k++) begin
                    clock_ms = clock_ms + $urandom_range(0, 400);
                    offer_poll(make_poll(1'b0, clock_ms, $urandom_range(0, 4) == 0,
                                         $urandom));
                end
            end else begin
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                    offer_poll(make_poll($urandom_range(0, 7) == 0, $urandom,
                                         1'($urandom_range(0, 1)), $urandom));
            end
            done += len;
        end
    endtask

    initial
    begin : sink_pattern
        int seg;
        int mode;
        int period;
        int i;
        res_ch.ready <= 1'b0;
        forever begin
            seg    = $urandom_range(8, 120);
            mode   = $urandom_range(0, 3);
            period = $urandom_range(2, 6);
            for (i = 0; i < seg; i++) begin
                @(posedge clk);
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= (i % period) != 0;
                    default: res_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
            if (hold_req) begin
                hold_req = 1'b0;
                @(posedge clk);
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Run timed out with %0d results outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int step_no;
        poll_ch.valid <= 1'b0;
        poll_ch.data  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_TIME_OFFSET;
        cfg_ch.wdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // request and reply at time zero, then backoff, ignored replies and forced updates
        offer_poll(make_poll(1'b0, 32'd0, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'd0, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'd0, 1'b1, NTP_TO_UNIX));
        offer_poll(make_poll(1'b0, 32'd500, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'd600, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'd1502, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'd3000, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'd3100, 1'b1, 32'hFFFF_FFFF));
        offer_poll(make_poll(1'b0, 32'd4000, 1'b1, 32'd0));
        offer_poll(make_poll(1'b0, 32'd63100, 1'b1, 32'd0));
        offer_poll(make_poll(1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        offer_poll(make_poll(1'b0, 32'd0, 1'b1, 32'h5555_5555));
        offer_poll(make_poll(1'b0, 32'h7FFF_FFFF, 1'b1, 32'hAAAA_AAAA));
        offer_poll(make_poll(1'b1, 32'h1234_5678, 1'b1, 32'hDEAD_BEEF));
        offer_poll(make_poll(1'b0, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF));
        offer_poll(make_poll(1'b0, 32'h8000_03E9, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'h8000_03EA, 1'b0, 32'd0));
        offer_poll(make_poll(1'b0, 32'h8000_0BEA, 1'b1, 32'hE000_0000));

        for (step_no = 0; step_no < 5; step_no++) begin
            if (step_no > 0) begin
                settle();
                case (step_no)
                    1: program_regs(86400, 32'd0, 16'd0);
                    2: program_regs(-86400, 32'hFFFF_FFFF, 16'hFFFF);
                    3: program_regs($urandom_range(0, 172800) - 86400,
                                    $urandom_range(1, 200000),
                                    16'($urandom_range(0, 3000)));
                    default: program_regs($urandom_range(0, 172800) - 86400,
                                          INTERVAL_RST, TIMEOUT_RST);
                endcase
            end else begin
                hold_req = 1'b1;
            end
            run_random(ITEMS_PER_STEP);
        end

        settle();
        repeat (20) @(posedge clk);
        $display("Covered %0d polls and %0d results: %0d requests, %0d with purge, %0d syncs",
                 polls_seen, results_seen, sends_seen, purges_seen, syncs_seen);
        $display("Five register settings incl. offset and interval extremes, backoff cap, wrap");
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
